@@ sv/prf_pkg.sv @@
// shared constants and widths for the packet ring fifo
package prf_pkg;

    // ring geometry
    localparam int SLOT_BYTES = 64;
    localparam int SLOT_COUNT = 8;
    localparam int POP_CAP    = 64;

    // field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    // derived widths
    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int BADDR_W = $clog2(SLOT_COUNT * SLOT_BYTES);
    localparam int WCNT_W  = $clog2(SLOT_BYTES + 1);
    localparam int CMP_W   = (WCNT_W > LEN_W) ? WCNT_W : LEN_W;

    // request opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

endpackage

@@ sv/prf_if.sv @@
// valid/ready channel interfaces for push/pop requests and pop results
interface prf_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [prf_pkg::BYTE_W-1:0] in_byte;
    logic                       byte_present;
    logic                       last_in;
    logic [prf_pkg::LEN_W-1:0]  max_len;

    modport source (output valid, op, in_byte, byte_present, last_in, max_len,
                    input ready);
    modport sink (input valid, op, in_byte, byte_present, last_in, max_len,
                  output ready);
endinterface

interface prf_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [prf_pkg::BYTE_W-1:0] out_byte;
    logic                       out_valid;
    logic                       last_out;
    logic                       was_empty;
    logic                       overflow_seen;
    logic [prf_pkg::LEN_W-1:0]  pop_length;

    modport source (output valid, out_byte, out_valid, last_out, was_empty,
                    overflow_seen, pop_length, input ready);
    modport sink (input valid, out_byte, out_valid, last_out, was_empty,
                  overflow_seen, pop_length, output ready);
endinterface

@@ sv/prf_ram.sv @@
// generic single-write, single-read ram with registered read data
module prf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ sv/packet_ring_fifo.sv @@
// packet ring fifo top level: push/pop control around slot byte and length rams
//
//  channel | dir | handshake   | carries
//  --------+-----+-------------+-------------------------------------------------
//  req     | in  | valid/ready | op, in_byte, byte_present, last_in, max_len
//  rsp     | out | valid/ready | out_byte, out_valid, last_out, was_empty,
//          |     |             | overflow_seen, pop_length
//
// a push request is handled in the cycle it is taken; requests are taken only while
// no pop is active. a pop reads the length ram, then starts the byte ram reads, then
// gives one result per cycle while rsp does not stall; an empty ring or zero-length
// pop gives a single result with no byte.
// rsp stalls hold the pending ram read data; nothing is lost or re-read.
// rst_n clears indices, flags and handshake state; the rams are not cleared.
module packet_ring_fifo (
    input  logic clk,
    input  logic rst_n,
    prf_req_if.sink   req,
    prf_rsp_if.source rsp
);
    import prf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LEN    = 3'b010,
        ST_STREAM = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic              ovf_reg, ovf_next;
    logic [WCNT_W-1:0] wcnt_reg, wcnt_next;
    logic              mid_reg, mid_next;
    logic              drop_reg, drop_next;
    logic [LEN_W-1:0]  maxl_reg, maxl_next;
    logic              empty_reg, empty_next;
    logic              ov_seen_reg, ov_seen_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [LEN_W-1:0]  icnt_reg, icnt_next;
    logic              pend_reg, pend_next;

    logic              out_v_reg, out_v_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_valid_reg, out_valid_next;
    logic              last_out_reg, last_out_next;
    logic              was_empty_reg, was_empty_next;
    logic              ovs_reg, ovs_next;
    logic [LEN_W-1:0]  pop_len_reg, pop_len_next;

    // ram ports
    logic               byte_we, byte_re;
    logic [BADDR_W-1:0] byte_waddr, byte_raddr;
    logic [BYTE_W-1:0]  byte_rdata;
    logic               len_we, len_re;
    logic [WCNT_W-1:0]  len_wdata, len_rdata;

    // helpers
    logic              req_fire, out_free, capture, issue, last_cap;
    logic [IDX_W-1:0]  head_inc, tail_inc;
    logic              full, drop, store;
    logic [WCNT_W-1:0] wc_base, wc_after;
    logic [LEN_W-1:0]  maxl_sat;
    logic [CMP_W-1:0]  len_cmp, max_cmp;
    logic [LEN_W-1:0]  n_calc;

    prf_ram #(.WIDTH(BYTE_W), .DEPTH(SLOT_COUNT * SLOT_BYTES)) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (req.in_byte),
        .re    (byte_re),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    prf_ram #(.WIDTH(WCNT_W), .DEPTH(SLOT_COUNT)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (head_reg),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (tail_reg),
        .rdata (len_rdata)
    );

    // handshakes
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_v_reg || rsp.ready;

    // ring index wrap
    assign head_inc = (head_reg == IDX_W'(SLOT_COUNT - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(SLOT_COUNT - 1)) ? '0 : tail_reg + 1'b1;
    assign full     = (head_inc == tail_reg);

    // push bookkeeping: a packet's first item decides drop or keep
    assign wc_base  = mid_reg ? wcnt_reg : '0;
    assign drop     = mid_reg ? drop_reg : full;
    assign store    = !drop && req.byte_present && (wc_base < WCNT_W'(SLOT_BYTES));
    assign wc_after = store ? wc_base + 1'b1 : wc_base;
    assign byte_waddr = BADDR_W'(head_reg) * BADDR_W'(SLOT_BYTES) + BADDR_W'(wc_base);
    assign len_wdata  = wc_after;

    // pop length: min(stored length, saturated max_len)
    assign maxl_sat = (req.max_len > LEN_W'(POP_CAP)) ? LEN_W'(POP_CAP) : req.max_len;
    assign len_cmp  = CMP_W'(len_rdata);
    assign max_cmp  = CMP_W'(maxl_reg);
    assign n_calc   = (len_cmp < max_cmp) ? LEN_W'(len_cmp) : LEN_W'(max_cmp);

    // byte streaming: at most one ram read in flight
    assign capture  = (state_reg == ST_STREAM) && pend_reg && out_free;
    assign issue    = (state_reg == ST_STREAM) && (icnt_reg < n_reg)
                      && (!pend_reg || capture);
    assign last_cap = (icnt_reg == n_reg);
    assign byte_raddr = BADDR_W'(tail_reg) * BADDR_W'(SLOT_BYTES) + BADDR_W'(icnt_reg);

    // control and next-state logic
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        ovf_next       = ovf_reg;
        wcnt_next      = wcnt_reg;
        mid_next       = mid_reg;
        drop_next      = drop_reg;
        maxl_next      = maxl_reg;
        empty_next     = empty_reg;
        ov_seen_next   = ov_seen_reg;
        n_next         = n_reg;
        icnt_next      = icnt_reg;
        pend_next      = pend_reg;
        out_v_next     = out_v_reg && !rsp.ready;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg;
        last_out_next  = last_out_reg;
        was_empty_next = was_empty_reg;
        ovs_next       = ovs_reg;
        pop_len_next   = pop_len_reg;
        byte_we        = 1'b0;
        byte_re        = 1'b0;
        len_we         = 1'b0;
        len_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.op == OP_PUSH))
                begin
                    mid_next  = !req.last_in;
                    drop_next = drop;
                    wcnt_next = wc_after;
                    byte_we   = store;
                    if (!mid_reg && full)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (!drop && req.last_in)
                    begin
                        len_we    = 1'b1;
                        head_next = head_inc;
                    end
                end
                else if (req_fire)
                begin
                    ov_seen_next = ovf_reg;
                    ovf_next     = 1'b0;
                    empty_next   = (tail_reg == head_reg);
                    maxl_next    = maxl_sat;
                    len_re       = 1'b1;
                    state_next   = ST_LEN;
                end
            end

            ST_LEN:
            begin
                if (empty_reg || (n_calc == '0))
                begin
                    // single result with no byte
                    if (out_free)
                    begin
                        out_v_next     = 1'b1;
                        out_byte_next  = '0;
                        out_valid_next = 1'b0;
                        last_out_next  = 1'b1;
                        was_empty_next = empty_reg;
                        ovs_next       = ov_seen_reg;
                        pop_len_next   = '0;
                        if (!empty_reg)
                        begin
                            tail_next = tail_inc;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    n_next     = n_calc;
                    icnt_next  = '0;
                    pend_next  = 1'b0;
                    state_next = ST_STREAM;
                end
            end

            ST_STREAM:
            begin
                if (capture)
                begin
                    out_v_next     = 1'b1;
                    out_byte_next  = byte_rdata;
                    out_valid_next = 1'b1;
                    last_out_next  = last_cap;
                    was_empty_next = 1'b0;
                    ovs_next       = ov_seen_reg;
                    pop_len_next   = n_reg;
                    if (last_cap)
                    begin
                        tail_next  = tail_inc;
                        state_next = ST_IDLE;
                    end
                end
                if (issue)
                begin
                    byte_re   = 1'b1;
                    icnt_next = icnt_reg + 1'b1;
                end
                pend_next = issue || (pend_reg && !capture);
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            ovf_reg   <= 1'b0;
            wcnt_reg  <= '0;
            mid_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ovf_reg   <= ovf_next;
            wcnt_reg  <= wcnt_next;
            mid_reg   <= mid_next;
            drop_reg  <= drop_next;
            pend_reg  <= pend_next;
            out_v_reg <= out_v_next;
        end
    end

    // pop context and result payload
    always_ff @(posedge clk)
    begin
        maxl_reg      <= maxl_next;
        empty_reg     <= empty_next;
        ov_seen_reg   <= ov_seen_next;
        n_reg         <= n_next;
        icnt_reg      <= icnt_next;
        out_byte_reg  <= out_byte_next;
        out_valid_reg <= out_valid_next;
        last_out_reg  <= last_out_next;
        was_empty_reg <= was_empty_next;
        ovs_reg       <= ovs_next;
        pop_len_reg   <= pop_len_next;
    end

    // result channel
    assign rsp.valid         = out_v_reg;
    assign rsp.out_byte      = out_byte_reg;
    assign rsp.out_valid     = out_valid_reg;
    assign rsp.last_out      = last_out_reg;
    assign rsp.was_empty     = was_empty_reg;
    assign rsp.overflow_seen = ovs_reg;
    assign rsp.pop_length    = pop_len_reg;
endmodule

@@ sim/packet_ring_fifo_tb.sv @@
// self-checking testbench for the packet ring fifo with a ring predictor and random traffic
`timescale 1ns / 1ps

module packet_ring_fifo_tb;

    import prf_pkg::*;

    // one pop result as seen on the rsp channel
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              last_out;
        logic              was_empty;
        logic              overflow_seen;
        logic [LEN_W-1:0]  pop_length;
    } pop_result_t;

    logic clk;
    logic rst_n;

    prf_req_if req ();
    prf_rsp_if rsp ();

    packet_ring_fifo dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // image of the ring contents and control state
    logic [BYTE_W-1:0] ring_bytes [SLOT_COUNT][SLOT_BYTES];
    logic [LEN_W-1:0]  ring_len [SLOT_COUNT];
    logic [IDX_W-1:0]  head_slot = '0;
    logic [IDX_W-1:0]  tail_slot = '0;
    logic              drop_pending = 1'b0;
    logic [WCNT_W-1:0] fill_count = '0;
    logic              in_packet = 1'b0;
    logic              discarding = 1'b0;

    pop_result_t due_pop_results[$];
    int          error_count = 0;
    int          sent_items = 0;
    int          send_idle_pct = 20;
    int          recv_idle_pct = 82;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // advance the ring image by one request, queueing the pop results it causes
    function automatic void apply_to_ring_image(input logic op, input logic [BYTE_W-1:0] b,
                                                input logic present, input logic last,
                                                input logic [LEN_W-1:0] maxl);
        logic [IDX_W-1:0] next_slot;
        logic [LEN_W-1:0] n;
        logic [LEN_W-1:0] cap;
        logic             ov;
        pop_result_t      res;
        next_slot = IDX_W'((int'(head_slot) + 1) % SLOT_COUNT);
        if (op == OP_PUSH)
        begin
            // ring full check at a packet's first item
            if (!in_packet)
            begin
                discarding = (next_slot == tail_slot);
                if (discarding)
                    drop_pending = 1'b1;
                fill_count = '0;
            end
            in_packet = !last;
            if (!discarding)
            begin
                if (present && fill_count < SLOT_BYTES)
                begin
                    ring_bytes[head_slot][fill_count] = b;
                    fill_count++;
                end
                if (last)
                begin
                    ring_len[head_slot] = LEN_W'(fill_count);
                    head_slot = next_slot;
                end
            end
        end
        else
        begin
            ov = drop_pending;
            drop_pending = 1'b0;
            if (tail_slot == head_slot)
            begin
                res = '{out_byte: '0, out_valid: 1'b0, last_out: 1'b1, was_empty: 1'b1,
                        overflow_seen: ov, pop_length: '0};
                due_pop_results.push_back(res);
            end
            else
            begin
                cap = (maxl > POP_CAP) ? LEN_W'(POP_CAP) : maxl;
                n = ring_len[tail_slot];
                if (n > cap)
                    n = cap;
                if (n == 0)
                begin
                    res = '{out_byte: '0, out_valid: 1'b0, last_out: 1'b1, was_empty: 1'b0,
                            overflow_seen: ov, pop_length: '0};
                    due_pop_results.push_back(res);
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        res = '{out_byte: ring_bytes[tail_slot][i], out_valid: 1'b1,
                                last_out: (i == n - 1), was_empty: 1'b0,
                                overflow_seen: ov, pop_length: n};
                        due_pop_results.push_back(res);
                    end
                end
                tail_slot = IDX_W'((int'(tail_slot) + 1) % SLOT_COUNT);
            end
        end
    endfunction

    // drive one request, wait for it to be taken, then maybe idle
    task automatic issue_request(input logic op, input logic [BYTE_W-1:0] b,
                                 input logic present, input logic last,
                                 input logic [LEN_W-1:0] maxl);
        req.valid        <= 1'b1;
        req.op           <= op;
        req.in_byte      <= b;
        req.byte_present <= present;
        req.last_in      <= last;
        req.max_len      <= maxl;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        apply_to_ring_image(op, b, present, last, maxl);
        sent_items++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // hold off new requests until every due result has come out
    task automatic wait_drained();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (due_pop_results.size() != 0);
    endtask

    // whole packet with a simple byte pattern
    task automatic push_packet(input int n_bytes, input int pattern);
        if (n_bytes == 0)
            issue_request(OP_PUSH, 8'($urandom), 1'b0, 1'b1, 7'($urandom));
        for (int i = 0; i < n_bytes; i++)
            issue_request(OP_PUSH, 8'(pattern + 37 * i), 1'b1, i == n_bytes - 1, 7'($urandom));
    endtask

    task automatic pop_packet(input logic [LEN_W-1:0] maxl);
        issue_request(OP_POP, 8'($urandom), 1'($urandom), 1'($urandom), maxl);
    endtask

    // pop limit mix: mostly whole packets, some short and zero reads
    function automatic logic [LEN_W-1:0] pick_pop_limit();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return LEN_W'($urandom_range(127, 64));
        else if (r < 80)
            return LEN_W'($urandom_range(10, 0));
        else
            return LEN_W'($urandom);
    endfunction

    // pops on an empty ring, zero and saturated limits
    task automatic test_empty_ring();
        pop_packet(7'd0);
        pop_packet(7'd127);
        wait_drained();
    endtask

    // byte extremes, items without a byte, empty packet, short and zero reads
    task automatic test_byte_extremes();
        issue_request(OP_PUSH, 8'h00, 1'b1, 1'b0, 7'd0);
        issue_request(OP_PUSH, 8'h77, 1'b0, 1'b0, 7'd127);
        issue_request(OP_PUSH, 8'hFF, 1'b1, 1'b0, 7'd64);
        issue_request(OP_PUSH, 8'hA5, 1'b1, 1'b0, 7'd1);
        issue_request(OP_PUSH, 8'h5A, 1'b1, 1'b0, 7'd2);
        issue_request(OP_PUSH, 8'h3C, 1'b0, 1'b1, 7'd3);
        pop_packet(7'd64);
        push_packet(0, 0);
        pop_packet(7'd64);
        push_packet(3, 8'h11);
        pop_packet(7'd0);
        push_packet(3, 8'hC3);
        pop_packet(7'd1);
        pop_packet(7'd64);
        wait_drained();
    endtask

    // packet longer than a slot, read with a saturating limit
    task automatic test_long_packet();
        push_packet(SLOT_BYTES + 6, 8'h29);
        pop_packet(7'd127);
        wait_drained();
    endtask

    // fill the ring, drop a packet, see the sticky flag once
    task automatic test_overflow();
        for (int i = 0; i < SLOT_COUNT - 1; i++)
            push_packet(1, 8'h40 + i);
        push_packet(2, 8'hE1);
        pop_packet(7'd64);
        pop_packet(7'd64);
        for (int i = 0; i < SLOT_COUNT - 3; i++)
            pop_packet(7'd64);
        pop_packet(7'd64);
        wait_drained();
    endtask

    // pops in the middle of an incoming packet
    task automatic test_pop_during_push();
        issue_request(OP_PUSH, 8'h81, 1'b1, 1'b0, 7'd5);
        pop_packet(7'd64);
        issue_request(OP_PUSH, 8'h82, 1'b1, 1'b1, 7'd5);
        push_packet(2, 8'h90);
        issue_request(OP_PUSH, 8'h83, 1'b1, 1'b0, 7'd5);
        pop_packet(7'd64);
        issue_request(OP_PUSH, 8'h84, 1'b1, 1'b1, 7'd5);
        pop_packet(7'd64);
        pop_packet(7'd64);
        wait_drained();
    endtask

    // random request stream
    task automatic random_traffic(input int n_items);
        int   first;
        int   len;
        int   r;
        logic closed;
        first = sent_items;
        while (sent_items - first < n_items)
        begin
            if ($urandom_range(99) < 5)
                wait_drained();
            r = $urandom_range(99);
            if (r < 55)
            begin
                // packet length: mostly short, a few near or beyond a slot's size
                r = $urandom_range(99);
                if (r < 75)
                    len = $urandom_range(6, 0);
                else if (r < 95)
                    len = $urandom_range(20, 7);
                else
                    len = $urandom_range(SLOT_BYTES + 6, SLOT_BYTES - 4);
                closed = 1'b0;
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(99) < 10)
                        issue_request(OP_PUSH, 8'($urandom), 1'b0, 1'b0, 7'($urandom));
                    if ($urandom_range(99) < 6)
                        pop_packet(pick_pop_limit());
                    closed = (i == len - 1) && ($urandom_range(99) >= 20);
                    issue_request(OP_PUSH, 8'($urandom), 1'b1, closed, 7'($urandom));
                end
                if (!closed)
                    issue_request(OP_PUSH, 8'($urandom), 1'b0, 1'b1, 7'($urandom));
            end
            else if (r < 63)
            begin
                // noise request with every field random
                issue_request(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                              7'($urandom));
            end
            else
                pop_packet(pick_pop_limit());
        end
    endtask

    // pop results checker and random receiver stalls
    initial
    begin
        pop_result_t seen;
        pop_result_t want;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                seen = '{out_byte: rsp.out_byte, out_valid: rsp.out_valid,
                         last_out: rsp.last_out, was_empty: rsp.was_empty,
                         overflow_seen: rsp.overflow_seen, pop_length: rsp.pop_length};
                if (due_pop_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %p", seen));
                else
                begin
                    want = due_pop_results.pop_front();
                    if (seen !== want)
                        report_mismatch($sformatf("got %p want %p", seen, want));
                end
            end
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // test sequence
    initial
    begin
        rst_n            <= 1'b0;
        req.valid        <= 1'b0;
        req.op           <= OP_PUSH;
        req.in_byte      <= '0;
        req.byte_present <= 1'b0;
        req.last_in      <= 1'b0;
        req.max_len      <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 82;
        test_empty_ring();
        test_byte_extremes();
        test_long_packet();
        test_overflow();
        test_pop_during_push();
        random_traffic(20);
        wait_drained();

        send_idle_pct = 82;
        recv_idle_pct = 20;
        random_traffic(20);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(20);

        // drain and let the block settle
        wait_drained();
        repeat (20) @(posedge clk);
        if (due_pop_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_pop_results.size()));
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/prf_pkg.sv
sv/prf_if.sv
sv/prf_ram.sv
sv/packet_ring_fifo.sv
sim/packet_ring_fifo_tb.sv
